// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the link event recorder modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/lev_pkg.sv
// ----------------------------------------------------------------------------
// lev_pkg
// Types and constants of the link event recorder.
// ----------------------------------------------------------------------------
package lev_pkg;

  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam logic [2:0] ACT_DISCONNECT  = 3'd0;
  localparam logic [2:0] ACT_CONNECT     = 3'd1;
  localparam logic [2:0] ACT_SCAN_DONE   = 3'd2;
  localparam logic [2:0] ACT_RADIO_START = 3'd3;
  localparam logic [2:0] ACT_RADIO_STOP  = 3'd4;
  localparam logic [2:0] ACT_RSSI        = 3'd5;
  localparam logic [2:0] ACT_READ_EVENT  = 3'd6;
  localparam logic [2:0] ACT_READ_STAT   = 3'd7;

  localparam logic [5:0] STAT_DISCONNECTS = 6'd32;
  localparam logic [5:0] STAT_REJOINS     = 6'd33;
  localparam logic [5:0] STAT_CONNECTS    = 6'd34;
  localparam logic [5:0] STAT_SCANS       = 6'd35;
  localparam logic [5:0] STAT_SCAN_FAILS  = 6'd36;
  localparam logic [5:0] STAT_LAST_REASON = 6'd37;
  localparam logic [5:0] STAT_HEAD        = 6'd38;

  localparam logic [15:0] CNT_SAT        = 16'hFFFF;
  localparam logic [7:0]  REASON_STD_MAX = 8'd24;
  localparam logic [7:0]  REASON_EXT_MIN = 8'd200;
  localparam logic [7:0]  REASON_EXT_MAX = 8'd206;
  localparam logic [7:0]  REASON_NO_REJ  = 8'd202;
  localparam logic [7:0]  REASON_REJOIN  = 8'd2;
  localparam logic [4:0]  BUCKET_EXT     = 5'd25;

  typedef struct packed {
    logic [2:0]         action;
    logic [31:0]        time_ms;
    logic [7:0]         code;
    logic               has_bssid;
    logic [47:0]        bssid;
    logic [7:0]         channel;
    logic [31:0]        ap_count;
    logic signed [7:0]  rssi;
    logic [31:0]        seq;
    logic [5:0]         stat_index;
  } lev_item_t;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic [2:0]         kind;
    logic [7:0]         code;
    logic signed [31:0] value;
    logic [47:0]        bssid;
    logic [7:0]         channel;
    logic signed [7:0]  rssi;
  } lev_rec_t;

  localparam int REC_W = $bits(lev_rec_t);

  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] addr;
    lev_rec_t           rec;
  } lev_wr_t;

  typedef struct packed {
    logic        found;
    logic [31:0] stat_value;
  } lev_meta_t;

endpackage

// File: rtl/lev_ram.sv
// ----------------------------------------------------------------------------
// lev_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lev_state.sv
// ----------------------------------------------------------------------------
// lev_state
// Link tracking, counters, ring head, record build and read lookups for one item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lev_state import lev_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      upd,
  input  lev_item_t it,
  output lev_wr_t   wr,
  output lev_meta_t meta
);

  logic [31:0] head_r;
  logic [15:0] cnt_r [32];
  logic [31:0] disc_tot_r, rejoin_tot_r, conn_tot_r, scan_tot_r, fail_tot_r;
  logic [7:0]  last_reason_r;
  logic        linked_r;
  logic [47:0] link_bssid_r;
  logic [7:0]  link_chan_r;
  logic [31:0] link_time_r;
  logic [7:0]  last_rssi_r;
  logic [31:0] rssi_time_r;

  logic        is_disc, is_conn, is_scan, is_stop, is_rssi, push;
  logic [4:0]  bucket;
  logic        rejoin;
  logic [31:0] rssi_gap;
  logic        rssi_ok;
  logic [31:0] span;
  logic [47:0] bssid_in;
  lev_rec_t    rec;
  logic [31:0] stat;

  assign is_disc  = it.action == ACT_DISCONNECT;
  assign is_conn  = it.action == ACT_CONNECT;
  assign is_scan  = it.action == ACT_SCAN_DONE;
  assign is_stop  = it.action == ACT_RADIO_STOP;
  assign is_rssi  = it.action == ACT_RSSI;
  assign push     = it.action < ACT_RSSI;
  assign bssid_in = it.has_bssid ? it.bssid : 48'd0;

  always_comb begin
    if (it.code != 8'd0 && it.code <= REASON_STD_MAX) begin
      bucket = it.code[4:0];
    end else if (it.code >= REASON_EXT_MIN && it.code <= REASON_EXT_MAX) begin
      bucket = BUCKET_EXT + 5'(it.code - REASON_EXT_MIN);
    end else begin
      bucket = 5'd0;
    end
  end

  assign rejoin   = it.code == REASON_REJOIN ||
                    (it.code >= REASON_EXT_MIN && it.code != REASON_NO_REJ);
  assign rssi_gap = rssi_time_r - link_time_r;
  assign rssi_ok  = linked_r && rssi_time_r != 32'd0 && last_rssi_r != 8'd0 &&
                    !rssi_gap[31];

  always_comb begin
    rec         = '0;
    rec.time_ms = it.time_ms;
    rec.kind    = it.action;
    case (it.action)
      ACT_DISCONNECT: begin
        rec.code  = it.code;
        rec.value = -32'sd1;
        rec.bssid = bssid_in;
        if (linked_r && it.has_bssid && it.bssid == link_bssid_r) begin
          rec.channel = link_chan_r;
        end
        if (rssi_ok) begin
          rec.rssi  = last_rssi_r;
          rec.value = it.time_ms - rssi_time_r;
        end
      end
      ACT_CONNECT: begin
        rec.channel = it.channel;
        rec.bssid   = bssid_in;
      end
      ACT_SCAN_DONE: begin
        rec.code  = it.code;
        rec.value = it.ap_count;
      end
      default: ;
    endcase
  end

  assign wr.we   = upd && push;
  assign wr.addr = head_r[RING_AW-1:0];
  assign wr.rec  = rec;

  always_comb begin
    stat = 32'd0;
    if (!it.stat_index[5]) begin
      stat = {16'd0, cnt_r[it.stat_index[4:0]]};
    end else begin
      case (it.stat_index)
        STAT_DISCONNECTS: stat = disc_tot_r;
        STAT_REJOINS:     stat = rejoin_tot_r;
        STAT_CONNECTS:    stat = conn_tot_r;
        STAT_SCANS:       stat = scan_tot_r;
        STAT_SCAN_FAILS:  stat = fail_tot_r;
        STAT_LAST_REASON: stat = {24'd0, last_reason_r};
        STAT_HEAD:        stat = head_r;
        default:          stat = 32'd0;
      endcase
    end
  end

  assign span            = head_r - it.seq;
  assign meta.found      = it.action == ACT_READ_EVENT && span != 32'd0 &&
                           span < 32'(RING_DEPTH);
  assign meta.stat_value = it.action == ACT_READ_STAT ? stat : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      disc_tot_r    <= '0;
      rejoin_tot_r  <= '0;
      conn_tot_r    <= '0;
      scan_tot_r    <= '0;
      fail_tot_r    <= '0;
      last_reason_r <= '0;
      linked_r      <= 1'b0;
      link_bssid_r  <= '0;
      link_chan_r   <= '0;
      link_time_r   <= '0;
      last_rssi_r   <= '0;
      rssi_time_r   <= '0;
      for (int i = 0; i < 32; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (upd) begin
      if (push) begin
        head_r <= head_r + 32'd1;
      end
      if (is_disc) begin
        linked_r      <= 1'b0;
        disc_tot_r    <= disc_tot_r + 32'd1;
        last_reason_r <= it.code;
        if (rejoin) begin
          rejoin_tot_r <= rejoin_tot_r + 32'd1;
        end
        for (int i = 0; i < 32; i++) begin
          if (bucket == 5'(i) && cnt_r[i] != CNT_SAT) begin
            cnt_r[i] <= cnt_r[i] + 16'd1;
          end
        end
      end
      if (is_conn) begin
        linked_r     <= 1'b1;
        link_bssid_r <= bssid_in;
        link_chan_r  <= it.channel;
        link_time_r  <= it.time_ms;
        conn_tot_r   <= conn_tot_r + 32'd1;
      end
      if (is_scan) begin
        scan_tot_r <= scan_tot_r + 32'd1;
        if (it.code != 8'd0) begin
          fail_tot_r <= fail_tot_r + 32'd1;
        end
      end
      if (is_stop) begin
        linked_r <= 1'b0;
      end
      if (is_rssi && it.rssi != 8'sd0) begin
        last_rssi_r <= it.rssi;
        rssi_time_r <= it.time_ms == 32'd0 ? 32'd1 : it.time_ms;
      end
    end
  end

  `ASSERT_CLK(a_head_step, wr.we |=> head_r == $past(head_r) + 32'd1, "head did not step")
  `ASSERT_CLK(a_head_hold, !wr.we |=> head_r == $past(head_r), "head moved without a record")
  `ASSERT_CLK(a_link_drop, upd && (is_stop || is_disc) |=> !linked_r, "link not dropped")
  `ASSERT_CLK(a_rssi_time, rssi_time_r == 32'd0 |-> last_rssi_r == 8'd0, "sample without time")

endmodule

// File: rtl/link_event_recorder_unit.sv
// ----------------------------------------------------------------------------
// link_event_recorder_unit: link event recorder, one item per cycle.
// Pipeline: input register, state update with ring read, result register.
// Throughput one item per clock; a stalled output holds the whole pipeline.
// Synchronous active-low reset clears link state, counters, totals and head.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module link_event_recorder_unit import lev_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // time_ms, code, has_bssid, bssid, channel, ap_count, rssi, seq, stat_index
  input  logic [175:0] in_tdata,
  // action
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // ev_time_ms, ev_kind, ev_code, ev_value, ev_bssid, ev_channel, ev_rssi,
  // stat_value
  output logic [175:0] out_tdata,
  // found
  output logic [0:0]   out_tuser
);

  logic        adv;
  logic        v1_r, v2_r, out_valid_r;
  lev_item_t   it_r;
  lev_wr_t     wr;
  lev_meta_t   meta, meta_r;
  logic [REC_W-1:0] rd_data;
  lev_rec_t    rd_rec;
  lev_rec_t    out_rec_r;
  logic        out_found_r;
  logic [31:0] out_stat_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_tvalid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_r.action     <= in_tuser;
      it_r.time_ms    <= in_tdata[31:0];
      it_r.code       <= in_tdata[39:32];
      it_r.has_bssid  <= in_tdata[40];
      it_r.bssid      <= in_tdata[88:41];
      it_r.channel    <= in_tdata[96:89];
      it_r.ap_count   <= in_tdata[128:97];
      it_r.rssi       <= in_tdata[136:129];
      it_r.seq        <= in_tdata[168:137];
      it_r.stat_index <= in_tdata[174:169];
      meta_r          <= meta;
      out_found_r     <= meta_r.found;
      out_stat_r      <= meta_r.stat_value;
      out_rec_r       <= meta_r.found ? rd_rec : '0;
    end
  end

  lev_state u_state (
    .clk  (clk),
    .rst_n(rst_n),
    .upd  (adv && v1_r),
    .it   (it_r),
    .wr   (wr),
    .meta (meta)
  );

  lev_ram #(
    .WIDTH(REC_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (wr.we),
    .waddr(wr.addr),
    .wdata(wr.rec),
    .re   (adv),
    .raddr(it_r.seq[RING_AW-1:0]),
    .rdata(rd_data)
  );

  assign rd_rec = rd_data;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {5'd0, out_stat_r, out_rec_r.rssi, out_rec_r.channel,
                       out_rec_r.bssid, out_rec_r.value, out_rec_r.code,
                       out_rec_r.kind, out_rec_r.time_ms};

  `ASSERT_CLK(a_out_src, $rose(out_valid_r) |-> $past(v2_r), "result without a stage-2 item")
  `ASSERT_CLK(a_found_excl, out_valid_r && out_found_r |-> out_stat_r == 32'd0, "found with stat")
  `ASSERT_CLK(a_nofound_zero, out_valid_r && !out_found_r |-> out_rec_r == '0, "stale record")

endmodule
